>>> rtl/seqconv_pkg.sv
// Shared types and constants for the sequence convolution unit.
`timescale 1ns / 1ps
package seqconv_pkg;

  // Fixed field widths
  localparam int FUNC_W  = 2;
  localparam int ACC_W   = 37;
  localparam int INDEX_W = 6;
  localparam int CNT_W   = 6;   // holds a count up to the largest sequence length
  localparam int OUT_W   = 48;  // result_value and result_index, padded to bytes
  localparam int USER_W  = 2;
  localparam int Q_DEPTH = 2;   // run requests in flight: queued plus active

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND_A = 2'd0,
    FUNC_APPEND_B = 2'd1,
    FUNC_RUN      = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_EMIT
  } back_state_e;

  // One run request handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0] len_a;
    logic [CNT_W-1:0] len_b;
    logic             ovf;
    logic             bank;
  } cmd_t;

endpackage

>>> rtl/seqconv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module seqconv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/seqconv_queue.sv
// Two-entry queue of run requests between front and back.
`timescale 1ns / 1ps
module seqconv_queue
  import seqconv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t       entry_q [Q_DEPTH];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  // Pointer and fill bookkeeping
  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = entry_q[rptr_q];

endmodule

>>> rtl/seqconv_front.sv
// Front end: accepts requests, appends samples to the stores, queues runs.
`timescale 1ns / 1ps
module seqconv_front
  import seqconv_pkg::*;
#(
  parameter int MAX_LEN     = 32,
  parameter int SAMPLE_BITS = 16,
  parameter int IN_W        = 24,
  parameter int LW          = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_W-1:0]        s_axis_tdata,
  output logic                   wr_a_o,
  output logic                   wr_b_o,
  output logic [LW:0]            waddr_o,
  output logic [SAMPLE_BITS-1:0] wdata_o,
  output logic                   push_o,
  output cmd_t                   cmd_o,
  input  logic                   done_i
);

  logic [CNT_W-1:0] len_a_q, len_a_d;
  logic [CNT_W-1:0] len_b_q, len_b_d;
  logic             ovf_q, ovf_d;
  logic             bank_q, bank_d;
  logic [1:0]       busy_q, busy_d;   // runs queued or in progress
  logic             take;
  func_e            func;

  // With two runs in flight both banks are held, so stall the input
  assign s_axis_tready = (busy_q < 2'(Q_DEPTH));
  assign take          = s_axis_tvalid && s_axis_tready;
  assign func          = func_e'(s_axis_tdata[FUNC_W-1:0]);
  assign wdata_o       = s_axis_tdata[FUNC_W +: SAMPLE_BITS];

  // Request decode
  always_comb begin
    len_a_d = len_a_q;
    len_b_d = len_b_q;
    ovf_d   = ovf_q;
    bank_d  = bank_q;
    wr_a_o  = 1'b0;
    wr_b_o  = 1'b0;
    push_o  = 1'b0;
    waddr_o = {bank_q, len_a_q[LW-1:0]};
    cmd_o   = '{len_a: len_a_q, len_b: len_b_q, ovf: ovf_q, bank: bank_q};
    if (take) begin
      case (func)
        FUNC_APPEND_A: begin
          if (len_a_q < CNT_W'(MAX_LEN)) begin
            wr_a_o  = 1'b1;
            len_a_d = len_a_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end
        FUNC_APPEND_B: begin
          waddr_o = {bank_q, len_b_q[LW-1:0]};
          if (len_b_q < CNT_W'(MAX_LEN)) begin
            wr_b_o  = 1'b1;
            len_b_d = len_b_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end
        FUNC_RUN: begin
          push_o  = 1'b1;
          len_a_d = '0;
          len_b_d = '0;
          ovf_d   = 1'b0;
          bank_d  = ~bank_q;
        end
        default: begin
        end
      endcase
    end
    busy_d = busy_q + {1'b0, push_o} - {1'b0, done_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_a_q <= '0;
      len_b_q <= '0;
      ovf_q   <= 1'b0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      len_a_q <= len_a_d;
      len_b_q <= len_b_d;
      ovf_q   <= ovf_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end

endmodule

>>> rtl/seqconv_back.sv
// Back end: multiply-accumulate sequencer that produces one result per index.
`timescale 1ns / 1ps
module seqconv_back
  import seqconv_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int LW          = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  cmd_t                   cmd_i,
  output logic                   pop_o,
  output logic                   done_o,
  output logic [LW:0]            raddr_a_o,
  output logic [LW:0]            raddr_b_o,
  input  logic [SAMPLE_BITS-1:0] rdata_a_i,
  input  logic [SAMPLE_BITS-1:0] rdata_b_i,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_W-1:0]       m_axis_tdata,
  output logic                   m_axis_tlast,
  output logic [USER_W-1:0]      m_axis_tuser
);

  localparam int PW = 2 * SAMPLE_BITS;
  localparam int MW = (PW > ACC_W) ? PW : ACC_W;

  back_state_e         state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [INDEX_W-1:0]  k_q, k_d;
  logic [INDEX_W-1:0]  j_q, j_d;
  logic [INDEX_W-1:0]  jhi_q, jhi_d;
  logic [INDEX_W-1:0]  tot_q, tot_d;     // index of the final result
  logic                emp_q, emp_d;
  logic [ACC_W-1:0]    acc_q, acc_d;

  // Read / multiply pipeline
  logic                rv_q, rv_d, rlast_q, rlast_d;
  logic                pv_q, plast_q;
  logic signed [PW-1:0] prod_q;
  logic signed [MW-1:0] prod_ext;

  // Result register
  logic                ov_q, ov_d;
  logic [ACC_W-1:0]    oval_q, oval_d;
  logic [INDEX_W-1:0]  oidx_q, oidx_d;
  logic                olast_q, olast_d, oovf_q, oovf_d, oemp_q, oemp_d;

  logic [INDEX_W-1:0]  k_next, i_idx, jlo_next, jhi_next;
  logic [INDEX_W:0]    tot_full;
  logic                out_free, is_last;

  assign prod_ext = MW'(prod_q);
  assign i_idx    = k_q - j_q;
  assign raddr_a_o = {cmd_q.bank, j_q[LW-1:0]};
  assign raddr_b_o = {cmd_q.bank, i_idx[LW-1:0]};

  // Term range for the following output index
  always_comb begin
    k_next   = k_q + 1'b1;
    jlo_next = (k_next >= cmd_q.len_b) ? (k_next - cmd_q.len_b + 1'b1) : '0;
    jhi_next = (k_next < cmd_q.len_a) ? k_next : (cmd_q.len_a - 1'b1);
    tot_full = {1'b0, cmd_i.len_a} + {1'b0, cmd_i.len_b} - 7'd2;
  end

  assign out_free = !ov_q || m_axis_tready;
  assign is_last  = emp_q || (k_q == tot_q);

  // Sequencer
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    k_d     = k_q;
    j_d     = j_q;
    jhi_d   = jhi_q;
    tot_d   = tot_q;
    emp_d   = emp_q;
    acc_d   = acc_q;
    rv_d    = 1'b0;
    rlast_d = (j_q == jhi_q);
    pop_o   = 1'b0;
    done_o  = 1'b0;
    ov_d    = ov_q && !m_axis_tready;
    oval_d  = oval_q;
    oidx_d  = oidx_q;
    olast_d = olast_q;
    oovf_d  = oovf_q;
    oemp_d  = oemp_q;
    if (pv_q) begin
      acc_d = acc_q + prod_ext[ACC_W-1:0];
    end
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          k_d   = '0;
          j_d   = '0;
          jhi_d = '0;
          acc_d = '0;
          tot_d = tot_full[INDEX_W-1:0];
          if (cmd_i.len_a == '0 || cmd_i.len_b == '0) begin
            emp_d   = 1'b1;
            state_d = ST_EMIT;
          end else begin
            emp_d   = 1'b0;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        rv_d = 1'b1;
        j_d  = j_q + 1'b1;
        if (j_q == jhi_q) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (pv_q && plast_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          oval_d  = acc_q;
          oidx_d  = k_q;
          olast_d = is_last;
          oovf_d  = cmd_q.ovf;
          oemp_d  = emp_q;
          acc_d   = '0;
          if (is_last) begin
            done_o  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            k_d     = k_next;
            j_d     = jlo_next;
            jhi_d   = jhi_next;
            state_d = ST_ISSUE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rv_q    <= 1'b0;
      pv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= rv_d;
      pv_q    <= rv_q;
      ov_q    <= ov_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    k_q     <= k_d;
    j_q     <= j_d;
    jhi_q   <= jhi_d;
    tot_q   <= tot_d;
    emp_q   <= emp_d;
    acc_q   <= acc_d;
    rlast_q <= rlast_d;
    plast_q <= rlast_q;
    prod_q  <= $signed(rdata_a_i) * $signed(rdata_b_i);
    oval_q  <= oval_d;
    oidx_q  <= oidx_d;
    olast_q <= olast_d;
    oovf_q  <= oovf_d;
    oemp_q  <= oemp_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {{(OUT_W - ACC_W - INDEX_W){1'b0}}, oidx_q, oval_q};
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = {oemp_q, oovf_q};

endmodule

>>> rtl/sequence_convolution_unit.sv
// Sequence convolution unit: top level joining front, queue, stores and back.
// Append requests are taken one per cycle while fewer than two runs are in flight.
// A run of nonzero lengths la, lb gives la+lb-1 results; for result k the sequencer
// reads one product term per step, waits for the last product, then emits the result.
// An empty run (either length zero) gives a single result, flagged empty.
// Reset clears counts, dropped flag, queue and sequencer; stores stay unwritten.
`timescale 1ns / 1ps
module sequence_convolution_unit
  import seqconv_pkg::*;
#(
  parameter int MAX_LEN     = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [1:0] func, [SAMPLE_BITS+1:2] sample, zero padded
  input  logic [((FUNC_W+SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [36:0] result_value, [42:37] result_index, [47:43] zero
  output logic [OUT_W-1:0]    m_axis_tdata,
  output logic                m_axis_tlast,
  // [0] overflow, [1] empty_input
  output logic [USER_W-1:0]   m_axis_tuser
);

  localparam int IN_W = ((FUNC_W + SAMPLE_BITS + 7) / 8) * 8;
  localparam int LW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int RAM_DEPTH = 2 ** (LW + 1);   // two banks

  logic                   wr_a, wr_b, push, pop, done, cmd_valid;
  logic [LW:0]            waddr, raddr_a, raddr_b;
  logic [SAMPLE_BITS-1:0] wdata, rdata_a, rdata_b;
  cmd_t                   cmd_push, cmd_head;

  seqconv_front #(
    .MAX_LEN    (MAX_LEN),
    .SAMPLE_BITS(SAMPLE_BITS),
    .IN_W       (IN_W),
    .LW         (LW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .wr_a_o       (wr_a),
    .wr_b_o       (wr_b),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .push_o       (push),
    .cmd_o        (cmd_push),
    .done_i       (done)
  );

  seqconv_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_push),
    .pop_i  (pop),
    .valid_o(cmd_valid),
    .data_o (cmd_head)
  );

  seqconv_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(RAM_DEPTH)
  ) u_store_a (
    .clk_i  (clk_i),
    .we_i   (wr_a),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr_a),
    .rdata_o(rdata_a)
  );

  seqconv_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(RAM_DEPTH)
  ) u_store_b (
    .clk_i  (clk_i),
    .we_i   (wr_b),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr_b),
    .rdata_o(rdata_b)
  );

  seqconv_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .LW         (LW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd_head),
    .pop_o        (pop),
    .done_o       (done),
    .raddr_a_o    (raddr_a),
    .raddr_b_o    (raddr_b),
    .rdata_a_i    (rdata_a),
    .rdata_b_i    (rdata_b),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the sequence convolution unit.
`timescale 1ns / 1ps
module testbench;
  import seqconv_pkg::*;

  localparam int SEQ_MAX     = 32;
  localparam int SMP_W       = 16;
  localparam int IN_W        = ((FUNC_W + SMP_W + 7) / 8) * 8;
  localparam int RAND_ITEMS  = 56;
  localparam int STALL_LIMIT = 2000;
  localparam int END_WAIT    = 24;
  localparam int REPORT_MAX  = 10;
  localparam int DIR_ROWS    = 28;

  // func code the block must ignore
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // One output of a run
  typedef struct packed {
    logic [ACC_W-1:0]   value;
    logic [INDEX_W-1:0] index;
    logic               last;
    logic               ovf;
    logic               empty;
  } conv_result_t;

  // One directed row; typed rows carry their single result
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SMP_W-1:0]  sample;
    logic [7:0]        reps;
    logic              typed;
    logic [ACC_W-1:0]  value;
    logic              ovf;
    logic              empty;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tlast;
  logic [USER_W-1:0] m_axis_tuser;

  // Side info that travels with the request on the bus
  logic         req_typed;
  conv_result_t req_typed_result;

  // Predictor state
  logic signed [SMP_W-1:0] seq_a [SEQ_MAX];
  logic signed [SMP_W-1:0] seq_b [SEQ_MAX];
  int unsigned             len_a;
  int unsigned             len_b;
  logic                    dropped;
  conv_result_t            awaited_results [$];

  int  mismatches;
  int  quiet_cycles;
  bit  tx_gaps;
  bit  rx_gaps;

  dir_row_t dir_plan [DIR_ROWS] = '{
    '{FUNC_RUN,      16'h0000, 8'd1,  1'b1, 37'd0,                1'b0, 1'b1},
    '{FUNC_APPEND_A, 16'h8000, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_APPEND_B, 16'h8000, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_RUN,      16'hFFFF, 8'd1,  1'b1, 37'sd1073741824,      1'b0, 1'b0},
    '{FUNC_APPEND_A, 16'h7FFF, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_APPEND_B, 16'h8000, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_RUN,      16'h0000, 8'd1,  1'b1, -37'sd1073709056,     1'b0, 1'b0},
    '{FUNC_APPEND_A, 16'h7FFF, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_APPEND_B, 16'h7FFF, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_RUN,      16'h0000, 8'd1,  1'b1, 37'sd1073676289,      1'b0, 1'b0},
    '{FUNC_UNUSED,   16'hFFFF, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_APPEND_A, 16'h1234, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_RUN,      16'h0000, 8'd1,  1'b1, 37'd0,                1'b0, 1'b1},
    '{FUNC_APPEND_B, 16'h0001, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_UNUSED,   16'h5A5A, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_RUN,      16'h0000, 8'd1,  1'b1, 37'd0,                1'b0, 1'b1},
    '{FUNC_APPEND_A, 16'h8000, 8'd33, 1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_RUN,      16'h0000, 8'd1,  1'b1, 37'd0,                1'b1, 1'b1},
    '{FUNC_APPEND_A, 16'h8000, 8'd32, 1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_APPEND_B, 16'h8000, 8'd32, 1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_APPEND_B, 16'h7FFF, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_RUN,      16'h0000, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_APPEND_A, 16'h0001, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_APPEND_A, 16'hFFFF, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_APPEND_B, 16'h5555, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_APPEND_B, 16'hAAAA, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_APPEND_B, 16'h0000, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0},
    '{FUNC_RUN,      16'h0000, 8'd1,  1'b0, 37'd0,                1'b0, 1'b0}
  };

  sequence_convolution_unit #(
    .MAX_LEN     (SEQ_MAX),
    .SAMPLE_BITS (SMP_W)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Append one result to the tail of the expected list
  function automatic void queue_result(input conv_result_t r);
    awaited_results = {awaited_results, r};
  endfunction

  // Update sequence state for one request and queue the outputs it yields
  function automatic void convolve_request(input logic [FUNC_W-1:0] func,
                                           input logic [SMP_W-1:0] sample);
    logic signed [ACC_W-1:0] acc;
    conv_result_t            res;
    int                      total;
    case (func)
      FUNC_APPEND_A: begin
        if (len_a < SEQ_MAX) begin
          seq_a[len_a] = sample;
          len_a++;
        end else begin
          dropped = 1'b1;
        end
      end
      FUNC_APPEND_B: begin
        if (len_b < SEQ_MAX) begin
          seq_b[len_b] = sample;
          len_b++;
        end else begin
          dropped = 1'b1;
        end
      end
      FUNC_RUN: begin
        if (len_a == 0 || len_b == 0) begin
          res = '{value: '0, index: '0, last: 1'b1, ovf: dropped, empty: 1'b1};
          queue_result(res);
        end else begin
          total = len_a + len_b - 1;
          for (int k = 0; k < total; k++) begin
            acc = '0;
            for (int j = 0; j < len_a && j <= k; j++) begin
              if (k - j < len_b) acc = acc + seq_a[j] * seq_b[k-j];
            end
            res = '{value: acc, index: k[INDEX_W-1:0], last: (k == total - 1),
                    ovf: dropped, empty: 1'b0};
            queue_result(res);
          end
        end
        len_a   = 0;
        len_b   = 0;
        dropped = 1'b0;
      end
      default: ;  // unused code leaves state alone
    endcase
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("%t %s", $realtime, msg);
  endtask

  // Prediction and checking on both handshakes, plus the stall watchdog
  always @(posedge clk_i) begin
    conv_result_t got;
    conv_result_t want;
    bit           fired;
    fired = 1'b0;
    if (s_axis_tvalid && s_axis_tready) begin
      fired = 1'b1;
      convolve_request(s_axis_tdata[FUNC_W-1:0], s_axis_tdata[FUNC_W+SMP_W-1:FUNC_W]);
      if (req_typed) begin
        void'(awaited_results.pop_back());
        queue_result(req_typed_result);
      end
    end
    if (m_axis_tvalid && m_axis_tready) begin
      fired = 1'b1;
      got = '{value: m_axis_tdata[ACC_W-1:0], index: m_axis_tdata[ACC_W+INDEX_W-1:ACC_W],
              last: m_axis_tlast, ovf: m_axis_tuser[0], empty: m_axis_tuser[1]};
      if (awaited_results.size() == 0) begin
        report($sformatf("unexpected result: value %0d index %0d last %0b ovf %0b empty %0b",
                         $signed(got.value), got.index, got.last, got.ovf, got.empty));
      end else begin
        want = awaited_results.pop_front();
        if (got !== want)
          report($sformatf({"result mismatch: want value %0d index %0d last %0b ovf %0b ",
                            "empty %0b, got value %0d index %0d last %0b ovf %0b empty %0b"},
                           $signed(want.value), want.index, want.last, want.ovf, want.empty,
                           $signed(got.value), got.index, got.last, got.ovf, got.empty));
      end
    end
    if (fired) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Result side: ready with random stall bursts
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_gaps && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one request, with an optional idle burst ahead of it
  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [SMP_W-1:0] sample,
                              input logic typed, input conv_result_t typed_result);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    s_axis_tvalid    <= 1'b1;
    s_axis_tdata     <= {{(IN_W - FUNC_W - SMP_W){1'b0}}, sample, func};
    req_typed        <= typed;
    req_typed_result <= typed_result;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold off the sender until every queued result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (awaited_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Main stimulus
  initial begin
    conv_result_t none;
    conv_result_t typed_res;
    int           rand_items;
    int           seq_no;
    int           need_a;
    int           need_b;
    bit           quiet;
    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    req_typed        = 1'b0;
    req_typed_result = '0;
    len_a            = 0;
    len_b            = 0;
    dropped          = 1'b0;
    mismatches       = 0;
    quiet_cycles     = 0;
    tx_gaps          = 1'b1;
    rx_gaps          = 1'b1;
    none             = '0;
    rand_items       = 0;
    seq_no           = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    foreach (dir_plan[r]) begin
      typed_res = '{value: dir_plan[r].value, index: '0, last: 1'b1,
                    ovf: dir_plan[r].ovf, empty: dir_plan[r].empty};
      for (int n = 0; n < dir_plan[r].reps; n++)
        send_request(dir_plan[r].func, dir_plan[r].sample, dir_plan[r].typed, typed_res);
    end
    drain_results();

    // Random runs of random length, with some noise and overlong sequences that drop samples
    while (rand_items < RAND_ITEMS) begin
      seq_no++;
      quiet   = rand_items > RAND_ITEMS * 4 / 5;
      tx_gaps = !quiet && $urandom_range(0, 3) != 0;
      rx_gaps = !quiet && $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 11) == 0) begin
        need_a = $urandom_range(20, 34);
        need_b = $urandom_range(20, 34);
      end else begin
        need_a = $urandom_range(0, 6);
        need_b = $urandom_range(0, 6);
      end
      while (need_a > 0 || need_b > 0) begin
        if (need_a > 0 && (need_b == 0 || $urandom_range(0, 1) == 1)) begin
          send_request(FUNC_APPEND_A, pick_sample(), 1'b0, none);
          need_a--;
        end else begin
          send_request(FUNC_APPEND_B, pick_sample(), 1'b0, none);
          need_b--;
        end
        rand_items++;
        if ($urandom_range(0, 15) == 0) send_request(FUNC_UNUSED, 16'($urandom), 1'b0, none);
      end
      // most sequences end in a run; the rest carry over into the next one
      if ($urandom_range(0, 9) != 0) begin
        send_request(FUNC_RUN, 16'($urandom), 1'b0, none);
        rand_items++;
      end
      if (seq_no % 7 == 0) drain_results();
    end

    // Wind down
    drain_results();
    repeat (END_WAIT) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
